[src/lhs_pkg.sv]
// Package with the shared constants, codes and helper functions of the latency histogram.
package lhs_pkg;

  localparam int LAST_BIN    = 200;
  localparam int COUNT_BITS  = 32;
  localparam int RTT_BITS    = 24;
  localparam int BIN_BITS    = $clog2(LAST_BIN + 1);
  localparam int STEP_BITS   = $clog2(BIN_BITS);
  localparam int SUM_BITS    = 56;
  localparam int SQ_BITS     = 64;
  localparam int WIDTH_BITS  = 3;
  localparam int CUTOFF_BITS = 10;
  localparam int CFG_DATA_BITS = 10;
  localparam int CFG_IDX_BITS  = 1;
  localparam int US_PER_MS   = 1000;
  localparam int DIV_BITS    = 13;
  localparam int CUT_US_BITS = CUTOFF_BITS + 10;
  localparam int CMP_BITS    = RTT_BITS + BIN_BITS;

  localparam logic [WIDTH_BITS-1:0]  BIN_WIDTH_RESET = WIDTH_BITS'(5);
  localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET    = CUTOFF_BITS'(100);

  typedef enum logic [1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_TIMEOUT = 2'd1,
    MODE_READ    = 2'd2,
    MODE_CLEAR   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BIN_WIDTH = 1'b0,
    CFG_CUTOFF    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  // Bin width in microseconds; a width of zero counts as one millisecond.
  function automatic logic [DIV_BITS-1:0] bin_divisor(input logic [WIDTH_BITS-1:0] w);
    logic [DIV_BITS-1:0] ms;
    ms = (w == '0) ? DIV_BITS'(1) : DIV_BITS'(w);
    return DIV_BITS'(ms * DIV_BITS'(US_PER_MS));
  endfunction

  // Smallest sample that is clipped into the last bin regardless of the quotient.
  function automatic logic [CMP_BITS-1:0] clip_limit(input logic [WIDTH_BITS-1:0] w);
    return CMP_BITS'(CMP_BITS'(bin_divisor(w)) * CMP_BITS'(LAST_BIN + 1));
  endfunction

endpackage

[src/lhs_if.sv]
// Request and result channel interfaces of the latency histogram.
interface lhs_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [lhs_pkg::RTT_BITS-1:0]  rtt_us;
  logic [lhs_pkg::BIN_BITS-1:0]  bin_index;

  modport source(output valid, mode, rtt_us, bin_index, input ready);
  modport sink(input valid, mode, rtt_us, bin_index, output ready);
endinterface

interface lhs_res_if;
  logic                            valid;
  logic                            ready;
  logic [lhs_pkg::COUNT_BITS-1:0]  bin_count;
  logic [lhs_pkg::COUNT_BITS-1:0]  sample_count;
  logic [lhs_pkg::COUNT_BITS-1:0]  timeout_count;
  logic [lhs_pkg::COUNT_BITS-1:0]  below_cutoff_count;
  logic [lhs_pkg::RTT_BITS-1:0]    min_rtt;
  logic [lhs_pkg::RTT_BITS-1:0]    max_rtt;
  logic [lhs_pkg::SUM_BITS-1:0]    rtt_sum;
  logic [lhs_pkg::SQ_BITS-1:0]     rtt_square_sum;
  logic [lhs_pkg::COUNT_BITS-1:0]  peak_count;
  logic                            empty_res;

  modport source(output valid, bin_count, sample_count, timeout_count, below_cutoff_count,
                 min_rtt, max_rtt, rtt_sum, rtt_square_sum, peak_count, empty_res,
                 input ready);
  modport sink(input valid, bin_count, sample_count, timeout_count, below_cutoff_count,
               min_rtt, max_rtt, rtt_sum, rtt_square_sum, peak_count, empty_res,
               output ready);
endinterface

[src/latency_histogram_stats_top.sv]
// Top level of the round-trip-time histogram and statistics collector.
//
// Requests arrive on req_i: mode 0 adds a sample, 1 adds a timeout, 2 reads
// one bin and 3 clears all statistics. Every request yields exactly one result
// on res_o carrying the bin count and all running statistics after the event.
// The user must write bin width and cutoff on the cfg_* port only while the
// block is idle; the block itself does not enforce this. A sample is binned
// by a restoring divider that shares one subtractor, one quotient bit a cycle,
// then the bin memory is read through a register and written back. A sample
// passes the divide, read, update and finish steps, a bin read the read,
// update and finish steps, a timeout or a clear the update and finish steps.
// The result is valid on res_o in the cycle after the finish step loads it.
// A finished result waits in the output register while the next request is
// taken; if the receiver stalls, the next result waits in the finish step and
// the block takes no further request until the output register frees up.
// Reset, asynchronous and active low, empties all bins at once through their
// valid bits, clears the counts and sums, sets the minimum to all ones and
// restores a bin width of 5 ms and a cutoff of 100 ms.
module latency_histogram_stats_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lhs_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [lhs_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  lhs_req_if.sink                            req_i,
  lhs_res_if.source                          res_o
);

  localparam int CB = lhs_pkg::COUNT_BITS;
  localparam int RB = lhs_pkg::RTT_BITS;
  localparam int BB = lhs_pkg::BIN_BITS;

  lhs_pkg::state_e state_q, state_d;

  logic [lhs_pkg::WIDTH_BITS-1:0]  bin_width_q;
  logic [lhs_pkg::CUTOFF_BITS-1:0] cutoff_q;
  logic [lhs_pkg::CUT_US_BITS-1:0] cutoff_us_q;

  lhs_pkg::mode_e                  mode_q;
  logic [RB-1:0]                   rtt_q;
  logic [RB-1:0]                   rem_q;
  logic [BB-1:0]                   quot_q;
  logic [lhs_pkg::DIV_BITS-1:0]    divisor_q;
  logic [lhs_pkg::STEP_BITS-1:0]   step_q;
  logic                            clip_q;
  logic                            oor_q;
  logic [BB-1:0]                   addr_q;
  logic [2*RB-1:0]                 square_q;
  logic [CB-1:0]                   bin_count_q;

  logic [CB-1:0]                   bins_mem [0:lhs_pkg::LAST_BIN];
  logic [lhs_pkg::LAST_BIN:0]      bin_valid_q;
  logic [CB-1:0]                   mem_rd_q;
  logic                            rd_valid_q;

  logic [CB-1:0]                   samples_q;
  logic [CB-1:0]                   timeouts_q;
  logic [CB-1:0]                   below_q;
  logic [RB-1:0]                   smallest_q;
  logic [RB-1:0]                   largest_q;
  logic [lhs_pkg::SUM_BITS-1:0]    total_q;
  logic [lhs_pkg::SQ_BITS-1:0]     square_total_q;
  logic [CB-1:0]                   peak_q;

  logic                            out_valid_q;

  logic accept;
  logic div_last;
  logic load_out;
  logic in_update;

  // Shared subtractor of the divider.
  logic [lhs_pkg::STEP_BITS-1:0]   shamt;
  logic [lhs_pkg::CMP_BITS-1:0]    dshift;
  logic                            div_ge;
  logic [BB-1:0]                   quot_next;

  logic [CB-1:0]                   cur_count;
  logic [CB-1:0]                   new_count;
  logic [CB-1:0]                   new_timeouts;
  logic [lhs_pkg::SUM_BITS:0]      total_sum;
  logic [lhs_pkg::SQ_BITS:0]       square_sum;

  assign shamt     = lhs_pkg::STEP_BITS'(BB - 1) - step_q;
  assign dshift    = lhs_pkg::CMP_BITS'(divisor_q) << shamt;
  assign div_ge    = lhs_pkg::CMP_BITS'(rem_q) >= dshift;
  assign quot_next = {quot_q[BB-2:0], div_ge};

  assign cur_count    = rd_valid_q ? mem_rd_q : '0;
  assign new_count    = (cur_count == '1) ? cur_count : cur_count + CB'(1);
  assign new_timeouts = (timeouts_q == '1) ? timeouts_q : timeouts_q + CB'(1);
  assign total_sum    = {1'b0, total_q} + (lhs_pkg::SUM_BITS + 1)'(rtt_q);
  assign square_sum   = {1'b0, square_total_q} + (lhs_pkg::SQ_BITS + 1)'(square_q);

  always_comb begin
    state_d   = state_q;
    accept    = 1'b0;
    div_last  = 1'b0;
    load_out  = 1'b0;
    in_update = 1'b0;
    req_i.ready = 1'b0;
    unique case (state_q)
      lhs_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          accept = 1'b1;
          unique case (lhs_pkg::mode_e'(req_i.mode))
            lhs_pkg::MODE_SAMPLE:  state_d = lhs_pkg::ST_DIV;
            lhs_pkg::MODE_READ:    state_d = lhs_pkg::ST_READ;
            lhs_pkg::MODE_TIMEOUT,
            lhs_pkg::MODE_CLEAR:   state_d = lhs_pkg::ST_UPDATE;
            default:               state_d = lhs_pkg::ST_UPDATE;
          endcase
        end
      end
      lhs_pkg::ST_DIV: begin
        if (step_q == lhs_pkg::STEP_BITS'(BB - 1)) begin
          div_last = 1'b1;
          state_d  = lhs_pkg::ST_READ;
        end
      end
      lhs_pkg::ST_READ: begin
        state_d = lhs_pkg::ST_UPDATE;
      end
      lhs_pkg::ST_UPDATE: begin
        in_update = 1'b1;
        state_d   = lhs_pkg::ST_FINISH;
      end
      lhs_pkg::ST_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          load_out = 1'b1;
          state_d  = lhs_pkg::ST_IDLE;
        end
      end
      default: state_d = lhs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= lhs_pkg::BIN_WIDTH_RESET;
      cutoff_q    <= lhs_pkg::CUTOFF_RESET;
    end else if (cfg_we_i) begin
      unique case (lhs_pkg::cfg_idx_e'(cfg_idx_i))
        lhs_pkg::CFG_BIN_WIDTH: bin_width_q <= cfg_data_i[lhs_pkg::WIDTH_BITS-1:0];
        lhs_pkg::CFG_CUTOFF:    cutoff_q    <= cfg_data_i[lhs_pkg::CUTOFF_BITS-1:0];
        default:                ;
      endcase
    end
  end

  // Datapath registers of the request in flight.
  always_ff @(posedge clk_i) begin
    cutoff_us_q <= lhs_pkg::CUT_US_BITS'(cutoff_q * lhs_pkg::CUT_US_BITS'(lhs_pkg::US_PER_MS));
    if (accept) begin
      mode_q    <= lhs_pkg::mode_e'(req_i.mode);
      rtt_q     <= req_i.rtt_us;
      rem_q     <= req_i.rtt_us;
      quot_q    <= '0;
      step_q    <= '0;
      divisor_q <= lhs_pkg::bin_divisor(bin_width_q);
      clip_q    <= lhs_pkg::CMP_BITS'(req_i.rtt_us) >= lhs_pkg::clip_limit(bin_width_q);
      oor_q     <= req_i.bin_index > BB'(lhs_pkg::LAST_BIN);
      addr_q    <= (req_i.bin_index > BB'(lhs_pkg::LAST_BIN)) ? '0 : req_i.bin_index;
    end
    if (state_q == lhs_pkg::ST_DIV) begin
      square_q <= (2*RB)'(rtt_q) * (2*RB)'(rtt_q);
      step_q   <= step_q + lhs_pkg::STEP_BITS'(1);
      quot_q   <= quot_next;
      if (div_ge) begin
        rem_q <= rem_q - dshift[RB-1:0];
      end
      if (div_last) begin
        addr_q <= clip_q ? BB'(lhs_pkg::LAST_BIN) : quot_next;
      end
    end
    if (in_update) begin
      unique case (mode_q)
        lhs_pkg::MODE_SAMPLE: bin_count_q <= new_count;
        lhs_pkg::MODE_READ:   bin_count_q <= oor_q ? '0 : cur_count;
        default:              bin_count_q <= '0;
      endcase
    end
  end

  // Bin memory with registered read; the valid bit stands in for a cleared entry.
  always_ff @(posedge clk_i) begin
    mem_rd_q   <= bins_mem[addr_q];
    rd_valid_q <= bin_valid_q[addr_q];
    if (in_update && mode_q == lhs_pkg::MODE_SAMPLE) begin
      bins_mem[addr_q] <= new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= '0;
    end else if (in_update) begin
      if (mode_q == lhs_pkg::MODE_CLEAR) begin
        bin_valid_q <= '0;
      end else if (mode_q == lhs_pkg::MODE_SAMPLE) begin
        bin_valid_q[addr_q] <= 1'b1;
      end
    end
  end

  // Running statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      samples_q      <= '0;
      timeouts_q     <= '0;
      below_q        <= '0;
      smallest_q     <= '1;
      largest_q      <= '0;
      total_q        <= '0;
      square_total_q <= '0;
      peak_q         <= '0;
    end else if (in_update) begin
      unique case (mode_q)
        lhs_pkg::MODE_SAMPLE: begin
          samples_q <= (samples_q == '1) ? samples_q : samples_q + CB'(1);
          if (32'(rtt_q) <= 32'(cutoff_us_q)) begin
            below_q <= (below_q == '1) ? below_q : below_q + CB'(1);
          end
          if (rtt_q < smallest_q) begin
            smallest_q <= rtt_q;
          end
          if (rtt_q > largest_q) begin
            largest_q <= rtt_q;
          end
          total_q <= total_sum[lhs_pkg::SUM_BITS] ? '1 : total_sum[lhs_pkg::SUM_BITS-1:0];
          square_total_q <= square_sum[lhs_pkg::SQ_BITS] ? '1
                                                         : square_sum[lhs_pkg::SQ_BITS-1:0];
          if (new_count > peak_q) begin
            peak_q <= new_count;
          end
        end
        lhs_pkg::MODE_TIMEOUT: begin
          timeouts_q <= new_timeouts;
          if (new_timeouts > peak_q) begin
            peak_q <= new_timeouts;
          end
        end
        lhs_pkg::MODE_CLEAR: begin
          samples_q      <= '0;
          timeouts_q     <= '0;
          below_q        <= '0;
          smallest_q     <= '1;
          largest_q      <= '0;
          total_q        <= '0;
          square_total_q <= '0;
          peak_q         <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_o.bin_count          <= bin_count_q;
      res_o.sample_count       <= samples_q;
      res_o.timeout_count      <= timeouts_q;
      res_o.below_cutoff_count <= below_q;
      res_o.min_rtt            <= smallest_q;
      res_o.max_rtt            <= largest_q;
      res_o.rtt_sum            <= total_q;
      res_o.rtt_square_sum     <= square_total_q;
      res_o.peak_count         <= peak_q;
      res_o.empty_res          <= (samples_q == '0);
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

[src/lhs_checker.sv]
// Port-level checker of the latency histogram and its bind to the top level.
module lhs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [lhs_pkg::COUNT_BITS-1:0]     bin_count_i,
  input logic [lhs_pkg::COUNT_BITS-1:0]     sample_count_i,
  input logic [lhs_pkg::COUNT_BITS-1:0]     timeout_count_i,
  input logic [lhs_pkg::RTT_BITS-1:0]       min_rtt_i,
  input logic [lhs_pkg::RTT_BITS-1:0]       max_rtt_i,
  input logic [lhs_pkg::COUNT_BITS-1:0]     peak_count_i,
  input logic                               empty_res_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_count_i) && $stable(peak_count_i))
    else $error("stalled result changed");

  a_empty_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_res_i |-> sample_count_i == '0 && min_rtt_i == '1 && max_rtt_i == '0)
    else $error("empty result with sample statistics");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !empty_res_i |-> min_rtt_i <= max_rtt_i)
    else $error("minimum above maximum");

  a_peak_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> peak_count_i >= timeout_count_i && peak_count_i >= bin_count_i)
    else $error("peak below a bin or timeout count");

endmodule

bind latency_histogram_stats_top lhs_checker u_lhs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .bin_count_i     (res_o.bin_count),
  .sample_count_i  (res_o.sample_count),
  .timeout_count_i (res_o.timeout_count),
  .min_rtt_i       (res_o.min_rtt),
  .max_rtt_i       (res_o.max_rtt),
  .peak_count_i    (res_o.peak_count),
  .empty_res_i     (res_o.empty_res)
);
